>>> design/pccc_pkg.sv
// shared constants, register indexes and channel expansion functions
`timescale 1ns / 1ps

package pccc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ROI_ROW_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_ROW_END     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ANGLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_ANGLE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_ANGLE     = 3'd5;

    localparam logic [9:0]  RST_ROI_ROW_START   = 10'd0;
    localparam logic [10:0] RST_ROI_ROW_END     = 11'd240;
    localparam logic [9:0]  RST_PIXEL_THRESHOLD = 10'd25;
    localparam logic [7:0]  RST_CENTER_ANGLE    = 8'd70;
    localparam logic [7:0]  RST_RED_ANGLE       = 8'd95;
    localparam logic [7:0]  RST_GREEN_ANGLE     = 8'd45;

    localparam int NUM_CLASSES = 5;
    localparam int CLS_RED     = 0;
    localparam int CLS_GREEN   = 1;
    localparam int CLS_YELLOW  = 2;
    localparam int CLS_BLUE    = 3;
    localparam int CLS_MAGENTA = 4;

    typedef logic [NUM_CLASSES-1:0] class_hit_t;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_RED     = 3'd1;
    localparam logic [2:0] CMD_GREEN   = 3'd2;
    localparam logic [2:0] CMD_MAGENTA = 3'd3;
    localparam logic [2:0] CMD_BLUE    = 3'd4;

    localparam logic [7:0] DRIVE_SPEED = 8'd120;

    // x*255/31 through a reciprocal multiply, exact for all 5-bit x
    function automatic logic [7:0] expand5(input logic [4:0] x);
        logic [12:0] p;
        logic [28:0] q;
        p = 13'(x) * 13'd255;
        q = 29'(p) * 29'd33826;
        return q[27:20];
    endfunction

    // x*255/63 through a reciprocal multiply, exact for all 6-bit x
    function automatic logic [7:0] expand6(input logic [5:0] x);
        logic [13:0] p;
        logic [29:0] q;
        p = 14'(x) * 14'd255;
        q = 30'(p) * 30'd16645;
        return q[27:20];
    endfunction

endpackage

>>> design/pccc_classify.sv
// color class decision for one pixel word, exclusive priority cascade
`timescale 1ns / 1ps

module pccc_classify (
    input  logic [15:0]               pixel_raw,
    output pccc_pkg::class_hit_t      class_hit
);
    import pccc_pkg::*;

    localparam logic [9:0] RED_MIN    = 10'd80;
    localparam logic [9:0] RED_MARGIN = 10'd25;
    localparam logic [9:0] GRN_MIN    = 10'd80;
    localparam logic [9:0] GRN_MARGIN = 10'd20;
    localparam logic [9:0] YEL_R_MIN  = 10'd110;
    localparam logic [9:0] YEL_G_MIN  = 10'd75;
    localparam logic [9:0] YEL_B_MAX  = 10'd70;
    localparam logic [9:0] YEL_DIFF   = 10'd60;
    localparam logic [9:0] BLU_MIN    = 10'd100;
    localparam logic [9:0] BLU_R_MARG = 10'd30;
    localparam logic [9:0] BLU_G_MARG = 10'd20;
    localparam logic [9:0] MAG_RB_MIN = 10'd90;
    localparam logic [9:0] MAG_G_MAX  = 10'd60;

    logic [15:0] px;
    logic [9:0]  r;
    logic [9:0]  g;
    logic [9:0]  b;
    logic        is_red;
    logic        is_green;
    logic        is_yellow;
    logic        is_blue;
    logic        is_magenta;

    assign px = {pixel_raw[7:0], pixel_raw[15:8]};
    assign r  = {2'b00, expand5(px[15:11])};
    assign g  = {2'b00, expand6(px[10:5])};
    assign b  = {2'b00, expand5(px[4:0])};

    assign is_red     = (r > RED_MIN) && (r > g + RED_MARGIN) && (r > b + RED_MARGIN);
    assign is_green   = (g > GRN_MIN) && (g > r + GRN_MARGIN) && (g > b + GRN_MARGIN);
    assign is_yellow  = (r > YEL_R_MIN) && (g > YEL_G_MIN) && (b < YEL_B_MAX)
                        && (r < g + YEL_DIFF) && (g < r + YEL_DIFF);
    assign is_blue    = (b > BLU_MIN) && (b > r + BLU_R_MARG) && (b > g + BLU_G_MARG);
    assign is_magenta = (r > MAG_RB_MIN) && (b > MAG_RB_MIN) && (g < MAG_G_MAX);

    always_comb begin
        class_hit = '0;
        if (is_red) begin
            class_hit[CLS_RED] = 1'b1;
        end else if (is_green) begin
            class_hit[CLS_GREEN] = 1'b1;
        end else if (is_yellow) begin
            class_hit[CLS_YELLOW] = 1'b1;
        end else if (is_blue) begin
            class_hit[CLS_BLUE] = 1'b1;
        end else if (is_magenta) begin
            class_hit[CLS_MAGENTA] = 1'b1;
        end
    end

endmodule

>>> design/pixel_color_class_counter.sv
// top level: pixel word register, class counters and frame decision register
// a frame-end word passes the word register, then the result register once that is free
// throughput: one pixel word per cycle; a waiting result stalls only frame-end words
// the counter update and decision sit between the word register and result register
// reset: synchronous active-low aresetn clears counters and valid flags, loads config defaults
`timescale 1ns / 1ps

module pixel_color_class_counter #(
    parameter int COUNT_BITS = pccc_pkg::COUNT_BITS_DEF,
    parameter int COORD_BITS = pccc_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pccc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pccc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [15:0]                     s_pixel_raw,
    input  logic [COORD_BITS-1:0]           s_pixel_row,
    input  logic [COORD_BITS-1:0]           s_pixel_column,
    input  logic                            s_frame_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_steer_angle,
    output logic [7:0]                      m_drive_speed,
    output logic                            m_finish_seen,
    output logic [2:0]                      m_command_code
);
    import pccc_pkg::*;

    localparam int ROW_W = (COORD_BITS > 11) ? COORD_BITS : 11;
    localparam int CMP_W = (COUNT_BITS > 11) ? COUNT_BITS : 11;

    logic [9:0]  roi_row_start_reg;
    logic [10:0] roi_row_end_reg;
    logic [9:0]  pixel_threshold_reg;
    logic [7:0]  center_angle_reg;
    logic [7:0]  red_angle_reg;
    logic [7:0]  green_angle_reg;

    logic                  in_valid_reg;
    logic [15:0]           in_raw_reg;
    logic [COORD_BITS-1:0] in_row_reg;
    logic [COORD_BITS-1:0] in_col_reg;
    logic                  in_fend_reg;

    logic [COUNT_BITS-1:0] cnt_reg  [NUM_CLASSES];
    logic [COUNT_BITS-1:0] cnt_next [NUM_CLASSES];

    logic       out_valid_reg;
    logic [7:0] out_angle_reg;
    logic       out_finish_reg;
    logic [2:0] out_cmd_reg;

    class_hit_t  class_hit;
    logic        in_roi;
    logic        advance;
    logic        s_take;
    logic [7:0]  angle_next;
    logic [2:0]  cmd_next;
    logic        finish_next;
    logic [CMP_W-1:0] th_w;
    logic [CMP_W-1:0] th2_w;
    logic [CMP_W-1:0] red_w;
    logic [CMP_W-1:0] grn_w;
    logic [CMP_W-1:0] yel_w;
    logic [CMP_W-1:0] blu_w;
    logic [CMP_W-1:0] mag_w;

    pccc_classify u_classify (
        .pixel_raw (in_raw_reg),
        .class_hit (class_hit)
    );

    // a word without frame end never waits on the result side
    assign advance = in_valid_reg && (!in_fend_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign in_roi = !in_col_reg[0]
                    && (ROW_W'(in_row_reg) >= ROW_W'(roi_row_start_reg))
                    && (ROW_W'(in_row_reg) < ROW_W'(roi_row_end_reg))
                    && (in_row_reg[0] == roi_row_start_reg[0]);

    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            cnt_next[i] = cnt_reg[i];
            if (in_roi && class_hit[i] && (cnt_reg[i] != {COUNT_BITS{1'b1}})) begin
                cnt_next[i] = cnt_reg[i] + COUNT_BITS'(1);
            end
        end
    end

    assign th_w  = CMP_W'(pixel_threshold_reg);
    assign th2_w = CMP_W'({pixel_threshold_reg, 1'b0});
    assign red_w = CMP_W'(cnt_next[CLS_RED]);
    assign grn_w = CMP_W'(cnt_next[CLS_GREEN]);
    assign yel_w = CMP_W'(cnt_next[CLS_YELLOW]);
    assign blu_w = CMP_W'(cnt_next[CLS_BLUE]);
    assign mag_w = CMP_W'(cnt_next[CLS_MAGENTA]);

    assign finish_next = (yel_w > th2_w);

    always_comb begin
        angle_next = center_angle_reg;
        cmd_next   = CMD_NONE;
        if ((red_w > th_w) && (red_w > grn_w)) begin
            angle_next = red_angle_reg;
            cmd_next   = CMD_RED;
        end else if ((grn_w > th_w) && (grn_w > red_w)) begin
            angle_next = green_angle_reg;
            cmd_next   = CMD_GREEN;
        end else if (mag_w > th_w) begin
            cmd_next = CMD_MAGENTA;
        end else if (blu_w > th_w) begin
            cmd_next = CMD_BLUE;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_row_start_reg   <= RST_ROI_ROW_START;
            roi_row_end_reg     <= RST_ROI_ROW_END;
            pixel_threshold_reg <= RST_PIXEL_THRESHOLD;
            center_angle_reg    <= RST_CENTER_ANGLE;
            red_angle_reg       <= RST_RED_ANGLE;
            green_angle_reg     <= RST_GREEN_ANGLE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROI_ROW_START:   roi_row_start_reg   <= cfg_wdata[9:0];
                REG_ROI_ROW_END:     roi_row_end_reg     <= cfg_wdata[10:0];
                REG_PIXEL_THRESHOLD: pixel_threshold_reg <= cfg_wdata[9:0];
                REG_CENTER_ANGLE:    center_angle_reg    <= cfg_wdata[7:0];
                REG_RED_ANGLE:       red_angle_reg       <= cfg_wdata[7:0];
                REG_GREEN_ANGLE:     green_angle_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_raw_reg  <= s_pixel_raw;
            in_row_reg  <= s_pixel_row;
            in_col_reg  <= s_pixel_column;
            in_fend_reg <= s_frame_end;
        end
    end

    // class counters, cleared after each frame decision
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cnt_reg[i] <= in_fend_reg ? '0 : cnt_next[i];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_fend_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_fend_reg) begin
            out_angle_reg  <= angle_next;
            out_finish_reg <= finish_next;
            out_cmd_reg    <= cmd_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_steer_angle  = out_angle_reg;
    assign m_drive_speed  = DRIVE_SPEED;
    assign m_finish_seen  = out_finish_reg;
    assign m_command_code = out_cmd_reg;

endmodule

>>> design/pccc_checker.sv
// port-level checks for the class counter, attached by bind
`timescale 1ns / 1ps

module pccc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_frame_end,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_steer_angle,
    input logic [7:0] m_drive_speed,
    input logic       m_finish_seen,
    input logic [2:0] m_command_code
);
    import pccc_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_steer_angle)
            && $stable(m_finish_seen) && $stable(m_command_code))
        else $error("result word changed while stalled");

    // a result appears only after a frame-end word was taken
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_frame_end, 2))
        else $error("result without a frame-end word");

    a_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_drive_speed == DRIVE_SPEED)
        else $error("drive speed not fixed");

    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_command_code == CMD_NONE || m_command_code == CMD_RED
            || m_command_code == CMD_GREEN || m_command_code == CMD_MAGENTA
            || m_command_code == CMD_BLUE))
        else $error("command code out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pixel_color_class_counter pccc_checker u_pccc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_frame_end    (s_frame_end),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_steer_angle  (m_steer_angle),
    .m_drive_speed  (m_drive_speed),
    .m_finish_seen  (m_finish_seen),
    .m_command_code (m_command_code)
);
